@@ rtl/core/ptsb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsb_pkg
// shared types, constants and the cordic angle table for the scan binner
// ----------------------------------------------------------------------------
package ptsb_pkg;

	localparam int DefNumBins   = 4096;
	localparam int CordicSteps  = 24;
	localparam logic [15:0] NoReturn = 16'hFFFF;
	localparam logic [15:0] MaxRange = 16'd65534;
	localparam logic [31:0] GainInv  = 32'h9B74EDA8;

	localparam logic [1:0] CmdClear = 2'd0;
	localparam logic [1:0] CmdAdd   = 2'd1;
	localparam logic [1:0] CmdRead  = 2'd2;
	localparam logic [1:0] CmdNone  = 2'd3;

	localparam logic [1:0] RegNearLimit = 2'd0;
	localparam logic [1:0] RegGapLow    = 2'd1;
	localparam logic [1:0] RegGapHigh   = 2'd2;
	localparam logic [1:0] RegWindow    = 2'd3;

	// word handed from front (cordic) to back (bin store)
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] ang;
		logic [15:0] range;
		logic [11:0] read_bin;
	} job_t;

	typedef enum logic [1:0] {
		FrIdle,
		FrIter,
		FrScale,
		FrHold
	} fr_state_t;

	typedef enum logic [2:0] {
		BkIdle,
		BkClear,
		BkLook,
		BkScan,
		BkWrite,
		BkOut
	} bk_state_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				5'd0: r = 32'h20000000;
				5'd1: r = 32'h12E4051E;
				5'd2: r = 32'h09FB385B;
				5'd3: r = 32'h051111D4;
				5'd4: r = 32'h028B0D43;
				5'd5: r = 32'h0145D7E1;
				5'd6: r = 32'h00A2F61E;
				5'd7: r = 32'h00517C55;
				5'd8: r = 32'h0028BE53;
				5'd9: r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98;
				5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6;
				5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2FA;
				5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE;
				5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30;
				5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C;
				5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3;
				5'd23: r = 32'h00000051;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ rtl/core/ptsb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsb_front
// accepts input words, runs the vectoring cordic for adds, emits a job word
// ----------------------------------------------------------------------------
module ptsb_front
	import ptsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] x_mm,
	input  logic [15:0] y_mm,
	input  logic [11:0] read_bin,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);

	// idle, iterate, scale multiply, hold result
	fr_state_t   ph_q, ph_d;
	logic [4:0]  it_q;
	logic signed [25:0] x_q, y_q;
	logic [31:0] z_q, base_q;
	logic [1:0]  cmd_q;
	logic [11:0] rb_q;
	logic        axis_q;
	logic [31:0] axis_ang_q;
	logic [57:0] prod_q;

	logic signed [25:0] dx, dy, x0, y0;
	logic [31:0] at;
	logic [41:0] rnd;

	assign in_ready  = (ph_q == FrIdle);
	assign job_valid = (ph_q == FrHold);
	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign at = atan_turn(it_q);
	assign x0 = {{2{x_mm[15]}}, x_mm, 8'd0};
	assign y0 = {{2{y_mm[15]}}, y_mm, 8'd0};
	assign rnd = prod_q[57:16] + 42'd8388608;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= FrIdle;
			it_q <= '0;
		end else begin
			ph_q <= ph_d;
			if (ph_q == FrIter) it_q <= it_q + 5'd1;
			else it_q <= '0;
		end
	end

	always_comb begin
		ph_d = ph_q;
		unique case (ph_q)
			FrIdle: begin
				if (in_valid) ph_d = (command == CmdAdd) ? FrIter : FrHold;
			end
			FrIter: begin
				if (it_q == 5'(CordicSteps - 1)) ph_d = FrScale;
			end
			FrScale: ph_d = FrHold;
			FrHold: if (job_ready) ph_d = FrIdle;
			default: ph_d = FrIdle;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ph_q == FrIdle && in_valid) begin
			cmd_q  <= command;
			rb_q   <= read_bin;
			z_q    <= '0;
			axis_q <= (y_mm == 16'd0) || (x_mm == 16'd0);
			if (y_mm == 16'd0)
				axis_ang_q <= x_mm[15] ? 32'h80000000 : 32'h0;
			else
				axis_ang_q <= y_mm[15] ? 32'hC0000000 : 32'h40000000;
			if (x_mm[15]) begin
				x_q <= -x0;
				y_q <= -y0;
				base_q <= 32'h80000000;
			end else begin
				x_q <= x0;
				y_q <= y0;
				base_q <= '0;
			end
		end else if (ph_q == FrIter) begin
			if (!y_q[25]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end else if (ph_q == FrScale) begin
			// a single 26x32 product of the x magnitude and the gain inverse
			prod_q <= 58'(({32'd0, (x_q[25] ? 26'd0 : 26'(x_q))}) * {26'd0, GainInv});
		end
	end

	// rounding and saturation after the registered product
	logic [15:0] range_c;
	always_comb begin
		if (rnd[41:24] > 18'(MaxRange)) range_c = MaxRange;
		else range_c = rnd[39:24];
	end

	always_comb begin
		job.cmd      = cmd_q;
		job.read_bin = rb_q;
		job.range    = range_c;
		job.ang      = axis_q ? axis_ang_q : (z_q + base_q);
	end

endmodule

@@ rtl/core/ptsb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsb_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module ptsb_queue
	import ptsb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count");

endmodule

@@ rtl/core/ptsb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsb_back
// bin store: clear sweep, min update with neighbor scan, read
// ----------------------------------------------------------------------------
module ptsb_back
	import ptsb_pkg::*;
#(
	parameter int NUM_BINS = DefNumBins
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	input  logic [15:0] near_limit,
	input  logic [15:0] gap_low,
	input  logic [15:0] gap_high,
	input  logic [5:0]  window,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] bin,
	output logic [15:0] range_mm,
	output logic        stored,
	output logic        suppressed
);

	localparam int AW = $clog2(NUM_BINS);
	localparam int NW = AW + 7;
	localparam int N8 = NUM_BINS / 8;
	localparam int N38 = NUM_BINS * 3 / 8;
	localparam int N58 = NUM_BINS * 5 / 8;
	localparam int N78 = NUM_BINS * 7 / 8;

	logic [15:0] mem [NUM_BINS];
	logic [15:0] rdata_q;

	bk_state_t st_q, st_d;
	logic [AW:0]   cnt_q;
	logic [AW-1:0] idx_q;
	logic [15:0]   range_q;
	logic [1:0]    cmd_q;
	logic [5:0]    off_q;
	logic          side_q;
	logic          hit_q;
	logic          rd_pend_q;
	logic          boot_q;
	logic [11:0]   bin_q;
	logic [15:0]   orng_q;
	logic          ost_q, osup_q;

	// memory port control
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wdata;
	logic          re;

	logic [AW-1:0] idx_in;
	assign idx_in = AW'((64'(job.ang + 32'h80000000) * 64'(NUM_BINS)) >> 32);

	// neighbor address for the current offset, wide enough for any window
	logic [NW-1:0] nb_lo, nb_hi;
	logic          nb_ok;
	assign nb_lo = NW'(idx_q) - NW'(off_q);
	assign nb_hi = NW'(idx_q) + NW'(off_q);
	assign nb_ok = side_q ? (nb_hi < NW'(NUM_BINS)) : !nb_lo[NW-1];

	logic [16:0] lo_b, hi_b;
	logic        hit_now;
	assign lo_b = {1'b0, rdata_q} + {1'b0, gap_low};
	assign hi_b = {1'b0, rdata_q} + {1'b0, gap_high};
	assign hit_now = ({1'b0, range_q} >= lo_b) && ({1'b0, range_q} <= hi_b);

	logic sector;
	assign sector = (range_q < near_limit) && ((AW+1)'(idx_q) > (AW+1)'(N8))
		&& ((AW+1)'(idx_q) < (AW+1)'(N78))
		&& !(((AW+1)'(idx_q) > (AW+1)'(N38)) && ((AW+1)'(idx_q) < (AW+1)'(N58)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BkClear;
		else st_q <= st_d;
	end

	assign job_ready = (st_q == BkIdle);
	assign out_valid = (st_q == BkOut);

	always_comb begin
		st_d = st_q;
		we = 1'b0; waddr = cnt_q[AW-1:0]; wdata = NoReturn;
		re = 1'b0; raddr = idx_q;
		unique case (st_q)
			BkIdle: begin
				if (job_valid) begin
					if (job.cmd == CmdClear) st_d = BkClear;
					else if (job.cmd == CmdAdd) begin
						st_d = BkLook; re = 1'b1; raddr = idx_in;
					end else if (job.cmd == CmdRead) begin
						st_d = BkLook; re = 1'b1; raddr = AW'(job.read_bin);
					end else st_d = BkOut;
				end
			end
			BkClear: begin
				we = 1'b1;
				// the pass after reset gives no result word
				if (cnt_q == (AW+1)'(NUM_BINS - 1)) st_d = boot_q ? BkIdle : BkOut;
			end
			BkLook: begin
				if (cmd_q != CmdAdd || range_q >= rdata_q) st_d = BkOut;
				else if (!sector) st_d = BkWrite;
				else st_d = BkScan;
			end
			BkScan: begin
				// one neighbor read per cycle; each result is checked in the following cycle
				if (rd_pend_q && hit_now) st_d = BkOut;
				else if (off_q == window && side_q && !rd_pend_q) st_d = BkWrite;
				else if (off_q < window && nb_ok) begin
					re = 1'b1; raddr = side_q ? nb_hi[AW-1:0] : nb_lo[AW-1:0];
				end
			end
			BkWrite: begin
				we = 1'b1; waddr = idx_q; wdata = range_q; st_d = BkOut;
			end
			BkOut: if (out_ready) st_d = BkIdle;
			default: st_d = BkIdle;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_pend_q <= 1'b0;
			boot_q <= 1'b1;
		end else begin
			if (st_q == BkClear) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			rd_pend_q <= (st_q == BkScan) && re;
			if (st_q == BkClear && cnt_q == (AW+1)'(NUM_BINS - 1)) boot_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			BkIdle: if (job_valid) begin
				cmd_q <= job.cmd;
				range_q <= job.range;
				idx_q <= (job.cmd == CmdAdd) ? idx_in : AW'(job.read_bin);
				off_q <= '0;
				side_q <= 1'b0;
				hit_q <= 1'b0;
				ost_q <= 1'b0;
				osup_q <= 1'b0;
				orng_q <= NoReturn;
				bin_q <= 12'd0;
				if (job.cmd == CmdAdd) begin
					bin_q <= 12'(idx_in);
					orng_q <= job.range;
				end else if (job.cmd == CmdRead) begin
					bin_q <= job.read_bin;
				end
			end
			BkLook: begin
				if (cmd_q == CmdRead) begin
					orng_q <= ({{(32-AW){1'b0}}, idx_q} == 32'(bin_q))
						&& (32'(bin_q) < 32'(NUM_BINS)) ? rdata_q : NoReturn;
				end
			end
			BkScan: begin
				if (rd_pend_q && hit_now) begin
					hit_q <= 1'b1; osup_q <= 1'b1;
				end else if (!(off_q == window && side_q)) begin
					if (side_q) off_q <= off_q + 6'd1;
					side_q <= ~side_q;
				end
			end
			BkWrite: ost_q <= 1'b1;
			default: ;
		endcase
	end

	assign bin = bin_q;
	assign range_mm = orng_q;
	assign stored = ost_q;
	assign suppressed = osup_q;

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(stored && suppressed)) else $error("stored and suppressed");
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && suppressed |-> hit_q) else $error("suppress without hit");
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BkWrite |=> stored) else $error("write not flagged");

endmodule

@@ rtl/core/point_to_scan_binner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_scan_binner
// projects 2d points into a min-range angular scan store
// ----------------------------------------------------------------------------
// usage:
//   input word (in_valid/in_ready): command, x_mm, y_mm, read_bin
//   output word (out_valid/out_ready): bin, range_mm, stored, suppressed
//   config write (cfg_valid/cfg_ready, cfg_index, cfg_data), always ready
// front runs a 24-step cordic plus one scale multiply for adds and takes
// no new word until its job word is handed on; a two-word queue hands jobs
// to the back, which owns the bin memory.
// back: a read passes through its lookup state to the output state; an add
// looks its bin up, may scan with up to 2*window neighbor reads, one per
// cycle from the single memory port, then writes or answers; clear sweeps
// all NUM_BINS bins, one bin a cycle, and then answers.
// reset: registers reload defaults and the back runs a clearing pass over
// all NUM_BINS bins, with no result word, before accepting jobs; the front
// may still fill the queue.
// a stalled receiver holds the back in its output state; the front keeps
// working until the queue is full.
// ----------------------------------------------------------------------------
module point_to_scan_binner
	import ptsb_pkg::*;
#(
	parameter int NUM_BINS = DefNumBins
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] x_mm,
	input  logic [15:0] y_mm,
	input  logic [11:0] read_bin,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] bin,
	output logic [15:0] range_mm,
	output logic        stored,
	output logic        suppressed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [15:0] near_limit_q, gap_low_q, gap_high_q;
	logic [5:0]  window_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_limit_q <= 16'd900;
			gap_low_q <= 16'd75;
			gap_high_q <= 16'd400;
			window_q <= 6'd28;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegNearLimit: near_limit_q <= cfg_data;
				RegGapLow:    gap_low_q <= cfg_data;
				RegGapHigh:   gap_high_q <= cfg_data;
				RegWindow:    window_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	job_t f_job, b_job;
	logic f_valid, f_ready, b_valid, b_ready;

	ptsb_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .command, .x_mm, .y_mm, .read_bin,
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	ptsb_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
	);

	ptsb_back #(.NUM_BINS(NUM_BINS)) u_back (
		.clk, .arst_n, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
		.near_limit(near_limit_q), .gap_low(gap_low_q), .gap_high(gap_high_q),
		.window(window_q), .out_valid, .out_ready, .bin, .range_mm, .stored,
		.suppressed
	);

endmodule

@@ verif/tb_point_to_scan_binner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_to_scan_binner
// self-checking bench for the point to scan binner
// ----------------------------------------------------------------------------
// a queue of point / read / clear words feeds a clocked driver; every
// accepted word runs through an in-bench polar projection and bin store
// model, and the expected result words are checked in order by a clocked
// monitor. four phases vary the thresholds and the idle patterns, one of
// them with a long receiver hold-off so the block backs up
// ----------------------------------------------------------------------------
module tb_point_to_scan_binner;
	import ptsb_pkg::*;

	localparam int NBins      = 4096;
	localparam int WatchLimit = 40000;
	localparam int SettleCyc  = 400;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] x;
		logic [15:0] y;
		logic [11:0] rb;
	} point_word_t;

	typedef struct {
		logic [11:0] bin;
		logic [15:0] rng;
		logic        st;
		logic        sup;
	} scan_word_t;

	typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_t;

	// arctangent steps in units of 2^-32 turn
	localparam logic [31:0] AtanStep [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = CmdClear;
	logic [15:0] x_mm = '0;
	logic [15:0] y_mm = '0;
	logic [11:0] read_bin = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [11:0] bin;
	logic [15:0] range_mm;
	logic        stored;
	logic        suppressed;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = RegNearLimit;
	logic [15:0] cfg_data = '0;

	point_to_scan_binner dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model state: bin store and threshold registers
	logic [15:0] bin_store [NBins];
	int unsigned near_lim, gap_lo, gap_hi, win;

	point_word_t pending_q [$];
	scan_word_t  scan_q [$];
	int          err_count = 0;
	idle_mode_t  idle_mode = IdleNone;
	logic        hold_arm = 1'b0;
	int          hold_left = 0;
	logic [11:0] last_bin = '0;

	// range and binary angle of a point, vectoring cordic in fixed point
	function automatic void polar_of(input logic signed [15:0] px, input logic signed [15:0] py,
			output logic [15:0] rng, output logic [31:0] ang);
		longint      xv, yv, dx, dy;
		logic [31:0] z;
		logic [63:0] prod;
		z = 32'h0;
		xv = longint'(px) * 256;
		yv = longint'(py) * 256;
		if (xv < 0) begin
			xv = -xv;
			yv = -yv;
			z = 32'h80000000;
		end
		for (int i = 0; i < 24; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv += dx;
				yv -= dy;
				z += AtanStep[i];
			end else begin
				xv -= dx;
				yv += dy;
				z -= AtanStep[i];
			end
		end
		ang = z;
		// axis points take the exact angle
		if (py == 0)
			ang = (px < 0) ? 32'h80000000 : 32'h0;
		else if (px == 0)
			ang = (py > 0) ? 32'h40000000 : 32'hC0000000;
		if (xv < 0)
			xv = 0;
		prod = (64'(xv) * 64'h9B74EDA8 + (64'd1 << 39)) >> 40;
		rng = (prod > 64'd65534) ? MaxRange : prod[15:0];
	endfunction

	function automatic logic neighbor_close(input int unsigned rng, input int unsigned idx);
		int unsigned s;
		s = bin_store[idx];
		return rng >= s + gap_lo && rng <= s + gap_hi;
	endfunction

	// apply one accepted word to the store model, return the expected word
	function automatic scan_word_t bin_point(input point_word_t w);
		scan_word_t  r;
		logic [15:0] rng;
		logic [31:0] ang, sh;
		int unsigned idx;
		logic        hit;
		r = '{bin: '0, rng: NoReturn, st: 1'b0, sup: 1'b0};
		hit = 1'b0;
		case (w.cmd)
			CmdClear: begin
				foreach (bin_store[k])
					bin_store[k] = NoReturn;
			end
			CmdAdd: begin
				polar_of(w.x, w.y, rng, ang);
				sh = ang + 32'h80000000;
				idx = sh[31:20];
				r.bin = idx[11:0];
				r.rng = rng;
				if (rng < bin_store[idx]) begin
					// side sectors only, near points only
					if (rng < near_lim && idx > NBins / 8 && idx < NBins * 7 / 8 &&
							!(idx > NBins * 3 / 8 && idx < NBins * 5 / 8))
						for (int unsigned i = 0; i < win && !hit; i++) begin
							if (i <= idx && neighbor_close(rng, idx - i))
								hit = 1'b1;
							if (idx + i < NBins && neighbor_close(rng, idx + i))
								hit = 1'b1;
						end
					if (hit)
						r.sup = 1'b1;
					else begin
						bin_store[idx] = rng;
						r.st = 1'b1;
					end
				end
			end
			CmdRead: begin
				r.bin = w.rb;
				r.rng = bin_store[w.rb];
			end
			default: ;
		endcase
		return r;
	endfunction

	// driver: next word goes out when the current one is taken or none is up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				scan_q.push_back(bin_point('{cmd: command, x: x_mm, y: y_mm, rb: read_bin}));
			end
			if (!in_valid || in_ready) begin
				if (pending_q.size() > 0 && !((idle_mode == IdleSend &&
						$urandom_range(99) < 87) || (idle_mode == IdleBoth &&
						$urandom_range(99) < 17))) begin
					command  <= pending_q[0].cmd;
					x_mm     <= pending_q[0].x;
					y_mm     <= pending_q[0].y;
					read_bin <= pending_q[0].rb;
					in_valid <= 1'b1;
					void'(pending_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_arm && hold_left == 0)
			hold_left <= 1500;
		else if (hold_left > 1)
			hold_left <= hold_left - 1;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	// monitor: check each accepted result word against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (scan_q.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					if (bin !== scan_q[0].bin)
						report_mismatch("bin", bin, scan_q[0].bin);
					if (range_mm !== scan_q[0].rng)
						report_mismatch("range_mm", range_mm, scan_q[0].rng);
					if (stored !== scan_q[0].st)
						report_mismatch("stored", stored, scan_q[0].st);
					if (suppressed !== scan_q[0].sup)
						report_mismatch("suppressed", suppressed, scan_q[0].sup);
					void'(scan_q.pop_front());
				end
			end
			if (hold_left > 1)
				out_ready <= 1'b0;
			else if (idle_mode == IdleRecv)
				out_ready <= $urandom_range(99) >= 87;
			else if (idle_mode == IdleBoth)
				out_ready <= $urandom_range(99) >= 17;
			else
				out_ready <= 1'b1;
		end
	end

	// watchdog on cycles without any word moving
	int quiet_cyc = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cyc <= 0;
		else
			quiet_cyc <= quiet_cyc + 1;
		if (quiet_cyc >= WatchLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			RegNearLimit: near_lim = val;
			RegGapLow:    gap_lo = val;
			RegGapHigh:   gap_hi = val;
			RegWindow:    win = val & 16'h3F;
			default: ;
		endcase
	endtask

	task automatic queue_word(input logic [1:0] c, input int px, input int py,
			input logic [11:0] r);
		pending_q.push_back('{cmd: c, x: px[15:0], y: py[15:0], rb: r});
	endtask

	// random traffic: mostly near point pairs that probe the neighbor rule
	task automatic queue_random(input int n);
		int k, px, py, sel;
		k = 0;
		while (k < n) begin
			sel = $urandom_range(99);
			if (sel < 2) begin
				queue_word(CmdClear, $urandom, $urandom, 12'($urandom));
				k++;
			end else if (sel < 5) begin
				queue_word(CmdNone, $urandom, $urandom, 12'($urandom));
				k++;
			end else if (sel < 20) begin
				queue_word(CmdRead, 0, 0, ($urandom_range(1) != 0) ? 12'($urandom) :
					last_bin + 12'($urandom_range(6)) - 12'd3);
				k++;
			end else if (sel < 32) begin
				queue_word(CmdAdd, $urandom, $urandom, 12'($urandom));
				k++;
			end else begin
				// a near point, then a farther one at almost the same bearing
				px = $urandom_range(2400) - 1200;
				py = $urandom_range(2400) - 1200;
				queue_word(CmdAdd, px, py, 12'($urandom));
				queue_word(CmdAdd, px + px / 4 + $urandom_range(20) - 10,
					py + py / 4 + $urandom_range(20) - 10, 12'($urandom));
				k += 2;
			end
		end
	endtask

	task automatic drain();
		wait (pending_q.size() == 0 && !in_valid && scan_q.size() == 0);
		repeat (SettleCyc) @(posedge clk);
	endtask

	logic [15:0] rand_word;

	initial begin
		near_lim = 900;
		gap_lo = 75;
		gap_hi = 400;
		win = 28;
		foreach (bin_store[k])
			bin_store[k] = NoReturn;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: axes, origin, corners, angle pi, reads, unused command, clear
		queue_word(CmdAdd, 1000, 0, 0);
		queue_word(CmdAdd, 0, 1000, 0);
		queue_word(CmdAdd, -1000, 0, 0);
		queue_word(CmdAdd, 0, -1000, 0);
		queue_word(CmdAdd, 0, 0, 0);
		queue_word(CmdAdd, -32768, -32768, 0);
		queue_word(CmdAdd, 32767, 32767, 0);
		queue_word(CmdAdd, 32767, -32768, 0);
		queue_word(CmdAdd, -32768, 32767, 0);
		// near point below, then a farther one beside it is rejected
		queue_word(CmdAdd, 10, -500, 0);
		queue_word(CmdAdd, 12, -700, 0);
		queue_word(CmdAdd, 30, -650, 0);
		queue_word(CmdAdd, 9, -480, 0);
		queue_word(CmdRead, 0, 0, 12'd0);
		queue_word(CmdRead, 0, 0, 12'd4095);
		queue_word(CmdRead, 0, 0, 12'd1024);
		queue_word(CmdRead, 0, 0, 12'd2048);
		queue_word(CmdNone, -1, -1, 12'hFFF);
		queue_word(CmdClear, 0, 0, 0);
		queue_word(CmdRead, 0, 0, 12'd1024);
		queue_random(130);
		// hold the receiver off for a long stretch while words keep coming
		repeat (40) @(posedge clk);
		hold_arm <= 1'b1;
		@(posedge clk);
		hold_arm <= 1'b0;
		drain();

		// widest thresholds, receiver stalling
		write_reg(RegNearLimit, 16'hFFFF);
		write_reg(RegGapLow, 16'h0000);
		write_reg(RegGapHigh, 16'hFFFF);
		write_reg(RegWindow, 16'd63);
		idle_mode <= IdleRecv;
		queue_random(140);
		drain();

		// rule switched off, sender idle
		write_reg(RegNearLimit, 16'h0000);
		write_reg(RegWindow, 16'd0);
		idle_mode <= IdleSend;
		queue_random(140);
		drain();

		// random thresholds, both sides idling
		rand_word = 16'($urandom_range(3000));
		write_reg(RegNearLimit, rand_word);
		rand_word = 16'($urandom_range(200));
		write_reg(RegGapLow, rand_word);
		write_reg(RegGapHigh, rand_word + 16'($urandom_range(800)));
		write_reg(RegWindow, 16'($urandom_range(63)));
		idle_mode <= IdleBoth;
		queue_random(140);
		drain();

		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// remember the bin of the last point taken, so reads land near it
	always @(posedge clk) begin
		if (in_valid && in_ready && command == CmdAdd && scan_q.size() > 0)
			last_bin <= scan_q[$].bin;
	end

endmodule
